### rtl/gfc_pkg.sv
// Shared codes and constants of the GIF frame compositor.
package gfc_pkg;

  typedef logic [2:0] func_t;

  localparam func_t FUNC_PAL_WR   = 3'd0;
  localparam func_t FUNC_FRM_START = 3'd1;
  localparam func_t FUNC_PIXEL    = 3'd2;
  localparam func_t FUNC_FRM_END  = 3'd3;
  localparam func_t FUNC_CANVAS_RD = 3'd4;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [2:0] DISP_CLEAR   = 3'd2;
  localparam logic [2:0] DISP_RESTORE = 3'd3;

  localparam logic [19:0] DEFAULT_DELAY_MS = 20'd40;
  localparam logic [19:0] CS_TO_MS         = 20'd10;
  localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

endpackage

### rtl/gfc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### rtl/gif_frame_compositor_unit.sv
// Top level of the GIF frame compositor: canvas, save buffer, palette and control.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i, in_stall_o  | func_i .. transparent_color_i
//  out     | out_valid_o, out_stall_i| result_kind_o, pixel_rgba_o, delay_ms_o, clipped_o
//  cfg     | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// Palette writes load the palette. Raster pixels go through the palette read and the
// canvas write port; both run back to back. A canvas read uses the canvas read port
// and the read state. With disposal 3 a frame start saves the canvas and the frame
// end restores it; with disposal 2 the frame end clears the rectangle. After reset
// the canvas is cleared with input stalled.
// Input stalls while a result waits and another result-producing item arrives.
module gif_frame_compositor_unit #(
  parameter int MAX_WIDTH       = 256,
  parameter int MAX_HEIGHT      = 256,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gfc_pkg::func_t     func_i,
  input  logic [7:0]         color_index_i,
  input  logic [23:0]        color_rgb_i,
  input  logic [7:0]         x_pos_i,
  input  logic [7:0]         y_pos_i,
  input  logic [8:0]         frame_width_i,
  input  logic [8:0]         frame_height_i,
  input  logic               gce_present_i,
  input  logic [7:0]         gce_flags_i,
  input  logic [15:0]        delay_cs_i,
  input  logic [7:0]         transparent_color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               result_kind_o,
  output logic [31:0]        pixel_rgba_o,
  output logic [19:0]        delay_ms_o,
  output logic               clipped_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_wdata_i
);
  import gfc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);
  localparam logic [AW:0]   DEPTH_C = (AW+1)'(DEPTH);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_SAVE    = 3'd2;
  localparam logic [2:0] ST_RESTORE = 3'd3;
  localparam logic [2:0] ST_DISPOSE = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          cp_vld_q, cp_vld_d;
  logic [AW-1:0] cp_addr_q, cp_addr_d;
  logic [8:0]    dx_q, dx_d, dy_q, dy_d;
  logic [8:0]    canvas_w_q, canvas_h_q;
  logic [7:0]    left_q, left_d, top_q, top_d;
  logic [8:0]    rect_w_q, rect_w_d, rect_h_q, rect_h_d;
  logic [8:0]    cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic          transp_en_q, transp_en_d;
  logic [7:0]    transp_idx_q, transp_idx_d;
  logic [2:0]    disp_q, disp_d;
  logic [19:0]   delay_q, delay_d;
  logic          clip_q, clip_d;
  logic          pix_vld_q, pix_vld_d, pix_black_q, pix_black_d;
  logic [AW-1:0] pix_addr_q, pix_addr_d;
  logic          rd_in_q, rd_in_d;
  logic          out_vld_q, out_vld_d, out_kind_q, out_kind_d, out_clip_q, out_clip_d;
  logic [31:0]   out_rgba_q, out_rgba_d;
  logic [19:0]   out_delay_q, out_delay_d;

  logic          in_acc, out_free;
  logic [9:0]    px, py, dpx, dpy;
  logic [19:0]   delay_new;
  logic [2:0]    disp_new;

  logic          cv_we, cv_re, sv_we, sv_re, pal_we, pal_re;
  logic [AW-1:0] cv_waddr, cv_raddr;
  logic [31:0]   cv_wdata, cv_rdata, sv_rdata;
  logic [23:0]   pal_rdata;

  function automatic logic pos_inside(logic [9:0] x, logic [9:0] y,
                                      logic [8:0] cw, logic [8:0] ch);
    pos_inside = (x < {1'b0, cw}) && (32'(x) < 32'(MAX_WIDTH)) &&
                 (y < {1'b0, ch}) && (32'(y) < 32'(MAX_HEIGHT));
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [9:0] x, logic [9:0] y);
    cell_addr = AW'(AW'(y) * MW_A) + AW'(x);
  endfunction

  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) ||
                       (pix_vld_q && !(func_i inside {FUNC_PAL_WR, FUNC_PIXEL})) ||
                       ((func_i inside {FUNC_FRM_END, FUNC_CANVAS_RD}) && !out_free);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign px  = 10'(left_q) + 10'(cur_x_q);
  assign py  = 10'(top_q) + 10'(cur_y_q);
  assign dpx = 10'(left_q) + 10'(dx_q);
  assign dpy = 10'(top_q) + 10'(dy_q);
  assign delay_new = 20'(delay_cs_i) * CS_TO_MS;
  assign disp_new  = gce_present_i ? gce_flags_i[4:2] : disp_q;

  assign pal_we = in_acc && (func_i == FUNC_PAL_WR) &&
                  (32'(color_index_i) < 32'(PALETTE_ENTRIES));
  assign pal_re = in_acc && (func_i == FUNC_PIXEL);

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  cp_vld_d = 1'b0;  cp_addr_d = cp_addr_q;
    dx_d = dx_q;  dy_d = dy_q;
    left_d = left_q;  top_d = top_q;  rect_w_d = rect_w_q;  rect_h_d = rect_h_q;
    cur_x_d = cur_x_q;  cur_y_d = cur_y_q;
    transp_en_d = transp_en_q;  transp_idx_d = transp_idx_q;
    disp_d = disp_q;  delay_d = delay_q;  clip_d = clip_q;
    pix_vld_d = 1'b0;  pix_black_d = pix_black_q;  pix_addr_d = pix_addr_q;
    rd_in_d = rd_in_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_kind_d = out_kind_q;  out_rgba_d = out_rgba_q;
    out_delay_d = out_delay_q;  out_clip_d = out_clip_q;
    cv_we = 1'b0;  cv_waddr = pix_addr_q;  cv_wdata = '0;
    cv_re = 1'b0;  cv_raddr = cnt_q[AW-1:0];
    sv_we = 1'b0;  sv_re = 1'b0;

    if (pix_vld_q) begin
      cv_we    = 1'b1;
      cv_waddr = pix_addr_q;
      cv_wdata = pix_black_q ? {24'd0, ALPHA_OPAQUE} : {pal_rdata, ALPHA_OPAQUE};
    end

    case (state_q)
      ST_CLEAR: begin
        cv_we    = 1'b1;
        cv_waddr = cnt_q[AW-1:0];
        cv_wdata = '0;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DEPTH_C - 1'b1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (func_i)
            FUNC_FRM_START: begin
              left_d = x_pos_i;  top_d = y_pos_i;
              rect_w_d = frame_width_i;  rect_h_d = frame_height_i;
              cur_x_d = '0;  cur_y_d = '0;  clip_d = 1'b0;
              if (gce_present_i) begin
                transp_en_d = gce_flags_i[0];
                disp_d      = gce_flags_i[4:2];
                delay_d     = (delay_new == '0) ? DEFAULT_DELAY_MS : delay_new;
                if (gce_flags_i[0]) begin
                  transp_idx_d = transparent_color_i;
                end
              end
              if (disp_new == DISP_RESTORE) begin
                state_d = ST_SAVE;
                cnt_d   = '0;
              end
            end
            FUNC_PIXEL: begin
              if (rect_w_q != '0 && cur_y_q < rect_h_q) begin
                if (pos_inside(px, py, canvas_w_q, canvas_h_q)) begin
                  pix_vld_d   = !(transp_en_q && color_index_i == transp_idx_q);
                  pix_addr_d  = cell_addr(px, py);
                  pix_black_d = !(32'(color_index_i) < 32'(PALETTE_ENTRIES));
                end else begin
                  clip_d = 1'b1;
                end
                if (cur_x_q + 1'b1 >= rect_w_q) begin
                  cur_x_d = '0;
                  cur_y_d = cur_y_q + 1'b1;
                end else begin
                  cur_x_d = cur_x_q + 1'b1;
                end
              end
            end
            FUNC_FRM_END: begin
              out_vld_d = 1'b1;  out_kind_d = KIND_FRAME;  out_rgba_d = '0;
              out_delay_d = delay_q;  out_clip_d = clip_q;
              if (disp_q == DISP_CLEAR && rect_w_q != '0 && rect_h_q != '0) begin
                state_d = ST_DISPOSE;
                dx_d = '0;  dy_d = '0;
              end else if (disp_q == DISP_RESTORE) begin
                state_d = ST_RESTORE;
                cnt_d   = '0;
              end
            end
            FUNC_CANVAS_RD: begin
              rd_in_d  = pos_inside(10'(x_pos_i), 10'(y_pos_i), canvas_w_q, canvas_h_q);
              cv_re    = 1'b1;
              cv_raddr = cell_addr(10'(x_pos_i), 10'(y_pos_i));
              state_d  = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        out_vld_d = 1'b1;  out_kind_d = KIND_PIXEL;  out_delay_d = '0;  out_clip_d = 1'b0;
        out_rgba_d = rd_in_q ? cv_rdata : '0;
        state_d = ST_IDLE;
      end
      ST_SAVE, ST_RESTORE: begin
        if (cnt_q < DEPTH_C) begin
          cv_re     = (state_q == ST_SAVE);
          sv_re     = (state_q == ST_RESTORE);
          cp_vld_d  = 1'b1;
          cp_addr_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end else if (!cp_vld_q) begin
          state_d = ST_IDLE;
        end
        if (cp_vld_q) begin
          if (state_q == ST_SAVE) begin
            sv_we = 1'b1;
          end else begin
            cv_we    = 1'b1;
            cv_waddr = cp_addr_q;
            cv_wdata = sv_rdata;
          end
        end
      end
      ST_DISPOSE: begin
        cv_we    = pos_inside(dpx, dpy, canvas_w_q, canvas_h_q);
        cv_waddr = cell_addr(dpx, dpy);
        cv_wdata = '0;
        if (dx_q + 1'b1 >= rect_w_q) begin
          dx_d = '0;
          dy_d = dy_q + 1'b1;
          if (dy_q + 1'b1 >= rect_h_q) begin
            state_d = ST_IDLE;
          end
        end else begin
          dx_d = dx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;  cnt_q <= '0;  cp_vld_q <= 1'b0;
      canvas_w_q <= 9'd256;  canvas_h_q <= 9'd256;
      left_q <= '0;  top_q <= '0;  rect_w_q <= '0;  rect_h_q <= '0;
      cur_x_q <= '0;  cur_y_q <= '0;
      transp_en_q <= 1'b0;  transp_idx_q <= '0;  disp_q <= '0;
      delay_q <= '0;  clip_q <= 1'b0;
      pix_vld_q <= 1'b0;  out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;  cnt_q <= cnt_d;  cp_vld_q <= cp_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WIDTH) begin
          canvas_w_q <= cfg_wdata_i;
        end else begin
          canvas_h_q <= cfg_wdata_i;
        end
      end
      left_q <= left_d;  top_q <= top_d;  rect_w_q <= rect_w_d;  rect_h_q <= rect_h_d;
      cur_x_q <= cur_x_d;  cur_y_q <= cur_y_d;
      transp_en_q <= transp_en_d;  transp_idx_q <= transp_idx_d;  disp_q <= disp_d;
      delay_q <= delay_d;  clip_q <= clip_d;
      pix_vld_q <= pix_vld_d;  out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;  dx_q <= dx_d;  dy_q <= dy_d;
    pix_black_q <= pix_black_d;  pix_addr_q <= pix_addr_d;  rd_in_q <= rd_in_d;
    out_kind_q <= out_kind_d;  out_rgba_q <= out_rgba_d;
    out_delay_q <= out_delay_d;  out_clip_q <= out_clip_d;
  end

  gfc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_canvas (
    .clk_i, .we_i(cv_we), .waddr_i(cv_waddr), .wdata_i(cv_wdata),
    .re_i(cv_re), .raddr_i(cv_raddr), .rdata_o(cv_rdata)
  );

  gfc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_saved (
    .clk_i, .we_i(sv_we), .waddr_i(cp_addr_q), .wdata_i(cv_rdata),
    .re_i(sv_re), .raddr_i(cnt_q[AW-1:0]), .rdata_o(sv_rdata)
  );

  gfc_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_palette (
    .clk_i, .we_i(pal_we), .waddr_i(color_index_i[PW-1:0]), .wdata_i(color_rgb_i),
    .re_i(pal_re), .raddr_i(color_index_i[PW-1:0]), .rdata_o(pal_rdata)
  );

  assign out_valid_o   = out_vld_q;
  assign result_kind_o = out_kind_q;
  assign pixel_rgba_o  = out_rgba_q;
  assign delay_ms_o    = out_delay_q;
  assign clipped_o     = out_clip_q;
endmodule

### rtl/gfc_checker.sv
// Port-level checks of the GIF frame compositor and their binding.
module gfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [31:0] pixel_rgba_o,
  input logic [19:0] delay_ms_o,
  input logic        clipped_o
);
  import gfc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result item dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_PIXEL |-> delay_ms_o == '0 && !clipped_o)
    else $error("Canvas read item carries frame fields.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_FRAME |-> pixel_rgba_o == '0)
    else $error("Frame item carries pixel data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_PIXEL |->
      pixel_rgba_o[7:0] == 8'h00 || pixel_rgba_o[7:0] == ALPHA_OPAQUE)
    else $error("Canvas pixel has a partial alpha.");
endmodule

bind gif_frame_compositor_unit gfc_checker u_gfc_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .result_kind_o,
  .pixel_rgba_o, .delay_ms_o, .clipped_o
);

### dv/tb_gif_frame_compositor_unit.sv
// Self-checking testbench of the GIF frame compositor, with a built-in canvas predictor.
module tb_gif_frame_compositor_unit;
  import gfc_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [7:0]  cidx;
    logic [23:0] rgb;
    logic [7:0]  xp;
    logic [7:0]  yp;
    logic [8:0]  fw;
    logic [8:0]  fh;
    logic        gce;
    logic [7:0]  flags;
    logic [15:0] dcs;
    logic [7:0]  tcol;
  } gif_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] rgba;
    logic [19:0] delay;
    logic        clip;
  } gif_result_t;

  localparam int ITEM_W = $bits(gif_item_t);

  class frame_scoreboard;
    bit [31:0]   canvas [65536];
    bit [31:0]   saved [65536];
    bit [23:0]   palette [256];
    int          pal_list [$];
    bit          pal_known [256];
    int          cw, ch;
    int          rect_l, rect_t, rect_w, rect_h, cur_x, cur_y;
    bit          t_en;
    bit [7:0]    t_idx;
    bit [2:0]    disp;
    bit [19:0]   held_delay;
    bit          clip_seen;
    gif_result_t results_due [$];
    int          errors;
    int          checked;

    function new();
      cw = 256;
      ch = 256;
      foreach (canvas[i]) canvas[i] = '0;
    endfunction

    function bit on_canvas(int x, int y);
      return x < cw && x < 256 && y < ch && y < 256;
    endfunction

    function void set_size(logic idx, int val);
      if (idx == CFG_WIDTH) cw = val;
      else ch = val;
    endfunction

    function void apply_item(gif_item_t it);
      gif_result_t r;
      int x, y;
      case (it.func)
        FUNC_PAL_WR: begin
          palette[it.cidx] = it.rgb;
          if (!pal_known[it.cidx]) begin
            pal_known[it.cidx] = 1'b1;
            pal_list.push_back(it.cidx);
          end
        end
        FUNC_FRM_START: begin
          rect_l = it.xp;
          rect_t = it.yp;
          rect_w = it.fw;
          rect_h = it.fh;
          cur_x = 0;
          cur_y = 0;
          clip_seen = 1'b0;
          if (it.gce) begin
            t_en = it.flags[0];
            disp = it.flags[4:2];
            held_delay = it.dcs * CS_TO_MS;
            if (held_delay == 0) held_delay = DEFAULT_DELAY_MS;
            if (t_en) t_idx = it.tcol;
          end
          if (disp == DISP_RESTORE) saved = canvas;
        end
        FUNC_PIXEL: begin
          if (rect_w != 0 && cur_y < rect_h) begin
            x = rect_l + cur_x;
            y = rect_t + cur_y;
            if (on_canvas(x, y)) begin
              if (!(t_en && it.cidx == t_idx))
                canvas[y * 256 + x] = {palette[it.cidx], ALPHA_OPAQUE};
            end else begin
              clip_seen = 1'b1;
            end
            cur_x++;
            if (cur_x >= rect_w) begin
              cur_x = 0;
              cur_y++;
            end
          end
        end
        FUNC_FRM_END: begin
          r = '{kind: KIND_FRAME, rgba: '0, delay: held_delay, clip: clip_seen};
          results_due.push_back(r);
          if (disp == DISP_CLEAR) begin
            for (int j = 0; j < rect_h; j++)
              for (int i = 0; i < rect_w; i++)
                if (on_canvas(rect_l + i, rect_t + j))
                  canvas[(rect_t + j) * 256 + rect_l + i] = '0;
          end else if (disp == DISP_RESTORE) begin
            canvas = saved;
          end
        end
        FUNC_CANVAS_RD: begin
          r = '{kind: KIND_PIXEL, rgba: '0, delay: '0, clip: 1'b0};
          if (on_canvas(it.xp, it.yp)) r.rgba = canvas[int'(it.yp) * 256 + it.xp];
          results_due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(gif_result_t got);
      gif_result_t exp_r;
      checked++;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: %p", got);
        return;
      end
      exp_r = results_due.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch: expected kind %0d rgba %h delay %0d clip %0d, ",
                    "got kind %0d rgba %h delay %0d clip %0d"},
                   exp_r.kind, exp_r.rgba, exp_r.delay, exp_r.clip,
                   got.kind, got.rgba, got.delay, got.clip);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  func_t       func_i;
  logic [7:0]  color_index_i;
  logic [23:0] color_rgb_i;
  logic [7:0]  x_pos_i;
  logic [7:0]  y_pos_i;
  logic [8:0]  frame_width_i;
  logic [8:0]  frame_height_i;
  logic        gce_present_i;
  logic [7:0]  gce_flags_i;
  logic [15:0] delay_cs_i;
  logic [7:0]  transparent_color_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        result_kind_o;
  logic [31:0] pixel_rgba_o;
  logic [19:0] delay_ms_o;
  logic        clipped_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [8:0]  cfg_wdata_i;

  frame_scoreboard sb = new();
  int  items_sent;
  int  restore_budget;
  bit  busy_stretch;
  bit  long_hold_done;

  gif_frame_compositor_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{kind: result_kind_o, rgba: pixel_rgba_o, delay: delay_ms_o,
                        clip: clipped_o});
  end

  // Receiver: random stalls, plus one long hold-off while items keep arriving.
  initial begin
    int r;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && sb.checked >= 40) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (busy_stretch || r < 60) begin
          out_stall_i <= 1'b0;
        end else if (r < 96) begin
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(10, 40)) @(negedge clk_i);
        end
      end
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_stretch || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic gif_item_t random_item(func_t f);
    gif_item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.func = f;
    it.fw = 9'($urandom_range(0, 256));
    it.fh = 9'($urandom_range(0, 256));
    return it;
  endfunction

  function automatic logic [7:0] pick_index();
    if (sb.t_en && $urandom_range(0, 4) == 0) return sb.t_idx;
    return 8'(sb.pal_list[$urandom_range(0, sb.pal_list.size() - 1)]);
  endfunction

  task automatic send(input gif_item_t it);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= it.func;
    color_index_i <= it.cidx;
    color_rgb_i <= it.rgb;
    x_pos_i <= it.xp;
    y_pos_i <= it.yp;
    frame_width_i <= it.fw;
    frame_height_i <= it.fh;
    gce_present_i <= it.gce;
    gce_flags_i <= it.flags;
    delay_cs_i <= it.dcs;
    transparent_color_i <= it.tcol;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.apply_item(it);
    if (it.func <= FUNC_CANVAS_RD) items_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_size(input logic idx, input int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= 9'(val);
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.set_size(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [23:0] rgb);
    gif_item_t it;
    it = random_item(FUNC_PAL_WR);
    it.cidx = idx;
    it.rgb = rgb;
    send(it);
  endtask

  task automatic send_start(input int x, input int y, input int w, input int h,
                            input bit g, input logic [7:0] flags, input int dcs,
                            input logic [7:0] tcol);
    gif_item_t it;
    it = random_item(FUNC_FRM_START);
    it.xp = 8'(x);
    it.yp = 8'(y);
    it.fw = 9'(w);
    it.fh = 9'(h);
    it.gce = g;
    it.flags = flags;
    it.dcs = 16'(dcs);
    it.tcol = tcol;
    send(it);
  endtask

  task automatic send_pixel(input logic [7:0] idx);
    gif_item_t it;
    it = random_item(FUNC_PIXEL);
    it.cidx = idx;
    send(it);
  endtask

  task automatic send_read(input int x, input int y);
    gif_item_t it;
    it = random_item(FUNC_CANVAS_RD);
    it.xp = 8'(x);
    it.yp = 8'(y);
    send(it);
  endtask

  task automatic send_side_item();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) send_read($urandom_range(0, 255), $urandom_range(0, 255));
    else if (r < 8) send_pal(8'($urandom_range(0, 255)), 24'($urandom));
    else send(random_item(func_t'($urandom_range(5, 7))));
  endtask

  task automatic random_frame();
    int r, w, h, x, y, n;
    bit g;
    logic [2:0] d;
    logic [7:0] flags;
    busy_stretch = ($urandom_range(0, 3) == 0);
    g = ($urandom_range(0, 9) < 7);
    d = 3'($urandom_range(0, 7));
    if (d == DISP_RESTORE) begin
      if (restore_budget > 0 && $urandom_range(0, 5) == 0) restore_budget--;
      else d = 3'd1;
    end
    if (!g && sb.disp == DISP_RESTORE) g = 1'b1;
    flags = 8'($urandom_range(0, 255));
    flags[4:2] = d;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      w = 0;
      h = $urandom_range(0, 4);
    end else if (r == 1) begin
      w = 256;
      h = $urandom_range(1, 2);
    end else if (r == 2) begin
      w = 1;
      h = 256;
    end else if (r == 3) begin
      w = $urandom_range(1, 8);
      h = 0;
    end else begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
    end
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(240, 255);
      y = $urandom_range(240, 255);
    end else begin
      x = $urandom_range(0, (sb.cw > 256 ? 256 : sb.cw) - 1);
      y = $urandom_range(0, (sb.ch > 256 ? 256 : sb.ch) - 1);
    end
    send_start(x, y, w, h, g, flags, ($urandom_range(0, 5) == 0) ? 0 : $urandom,
               8'($urandom));
    n = (w * h > 40) ? 40 : w * h;
    if (w == 0 || $urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_side_item();
      send_pixel(pick_index());
    end
    if ($urandom_range(0, 2) == 0) send_read(x, y);
    send(random_item(FUNC_FRM_END));
    for (int i = $urandom_range(0, 3); i > 0; i--)
      send_read(x + $urandom_range(0, 3), y + $urandom_range(0, 3));
    busy_stretch = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (66000) @(posedge clk_i);
  endtask

  initial begin
    int widths [4];
    int heights [4];
    widths = '{256, 1, 0, 256};
    heights = '{256, 1, 0, 1};
    widths[2] = $urandom_range(2, 255);
    heights[2] = $urandom_range(2, 255);
    restore_budget = 2;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_PAL_WR;
    color_index_i = '0;
    color_rgb_i = '0;
    x_pos_i = '0;
    y_pos_i = '0;
    frame_width_i = '0;
    frame_height_i = '0;
    gce_present_i = 1'b0;
    gce_flags_i = '0;
    delay_cs_i = '0;
    transparent_color_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_size(CFG_WIDTH, widths[0]);
    write_size(CFG_HEIGHT, heights[0]);

    // Directed: transparency with a zero delay, clipping at the far corner,
    // persistence without a control block, empty rectangle, save and restore,
    // frame end without a start, and unused codes.
    send_pal(8'd0, 24'h000000);
    send_pal(8'd255, 24'hFFFFFF);
    send_pal(8'd85, 24'hA5A55A);
    send_start(0, 0, 2, 2, 1'b1, 8'h05, 0, 8'd255);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd85);
    send_pixel(8'd255);
    send_read(0, 0);
    send_read(1, 1);
    send(random_item(FUNC_FRM_END));
    send_start(254, 255, 256, 2, 1'b1, 8'hFA, 65535, 8'd0);
    send_pixel(8'd85);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send(random_item(FUNC_FRM_END));
    send_read(255, 255);
    send_start(3, 3, 0, 5, 1'b0, 8'h00, 0, 8'd0);
    send_pixel(8'd85);
    send(random_item(FUNC_FRM_END));
    send_start(10, 10, 3, 1, 1'b1, 8'h0C, 7, 8'd0);
    send_pixel(8'd85);
    send_pixel(8'd255);
    send_read(10, 10);
    send(random_item(FUNC_FRM_END));
    send(random_item(FUNC_FRM_END));
    send_read(11, 10);
    send(random_item(3'd5));
    send(random_item(3'd7));
    send_start(0, 0, 1, 1, 1'b1, 8'h00, 1, 8'd0);
    send(random_item(FUNC_FRM_END));

    for (int p = 0; p < 4; p++) begin
      if (p > 0) begin
        wait_idle();
        write_size(CFG_WIDTH, widths[p]);
        write_size(CFG_HEIGHT, heights[p]);
      end
      while (items_sent < 850 * (p + 1) / 4) begin
        if ($urandom_range(0, 7) == 0) send_side_item();
        else random_frame();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
